// ===== rtl/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and codes of the keyed record table: operation and status
// codes, the command that travels from the front to the back, and the result.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 16;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int CNT_OUT_W = 7;

    // packed stream widths, padded to whole bytes
    localparam int IN_FIELDS_W  = OP_W + KEY_W + VALUE_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + KEY_W + VALUE_W + CNT_OUT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DELETED   = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_DUMP      = 3'd6
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        t_status              status;
        logic [KEY_W-1:0]     key_out;
        logic [VALUE_W-1:0]   value_out;
        logic [CNT_OUT_W-1:0] entry_count_out;
        logic                 last;
    } t_res;

endpackage

// ===== rtl/krt_front.sv =====
// ----------------------------------------------------------------------------
// krt_front
// Accepts input transfers, decodes the operation and holds the commands in a
// two-entry queue that the back end drains at its own pace.
// ----------------------------------------------------------------------------
module krt_front import krt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_DATA_W-1:0] i_s_tdata,   // op, key, value (low bit first)
    output logic                 o_cmd_valid,
    output t_cmd                 o_cmd,
    input  logic                 i_cmd_pop
);

    t_cmd       r_queue [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill,   n_fill;
    logic       push;
    logic       pop;
    t_cmd       in_cmd;

    // field unpacking and operation decode
    always_comb begin
        in_cmd.op    = t_op'(i_s_tdata[OP_W-1:0]);
        in_cmd.key   = i_s_tdata[OP_W +: KEY_W];
        in_cmd.value = i_s_tdata[OP_W+KEY_W +: VALUE_W];
    end

    assign o_s_tready  = (r_fill != 2'd2);
    assign push        = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_queue[r_rd_ptr];

    // queue pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_fill   = r_fill + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

// ===== rtl/krt_back.sv =====
// ----------------------------------------------------------------------------
// krt_back
// Table of key/value cells with a comparator per cell and a sequencer that
// carries out add, search, delete and dump, with a registered result stage.
// ----------------------------------------------------------------------------
module krt_back import krt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_res_valid,
    output t_res o_res,
    input  logic i_res_ready
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_dump_idx, n_dump_idx;
    logic [TABLE_DEPTH-1:0] r_match;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] after;
    logic [TABLE_DEPTH-1:0] first;
    logic [TABLE_DEPTH-1:0] low_mask;
    logic                  hit;
    logic [VALUE_W-1:0]    found_val;
    logic [KEY_W-1:0]      r_key [TABLE_DEPTH];
    logic [VALUE_W-1:0]    r_val [TABLE_DEPTH];
    logic [KEY_W-1:0]      n_key [TABLE_DEPTH];
    logic [VALUE_W-1:0]    n_val [TABLE_DEPTH];
    t_res                  r_res, n_res;
    logic                  r_res_valid, n_res_valid;
    logic                  out_free;
    logic                  do_add;
    logic                  do_del;
    logic                  do_rot;

    assign out_free    = !r_res_valid || i_res_ready;
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // per-cell key compare against the queue head, limited to held entries
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            match_vec[i] = (r_key[i] == i_cmd.key) && (CW'(i) < r_count);
        end
    end

    // first match and everything at or after it
    always_comb begin
        found_val = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            low_mask  = {TABLE_DEPTH{1'b1}} >> (TABLE_DEPTH - 1 - i);
            after[i]  = |(r_match & low_mask);
            first[i]  = r_match[i] && !(|(r_match & (low_mask >> 1)));
            found_val = found_val | (first[i] ? r_val[i] : '0);
        end
        hit = |r_match;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dump_idx  = r_dump_idx;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_ready;
        do_add      = 1'b0;
        do_del      = 1'b0;
        do_rot      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd.op == OP_DUMP && r_count != '0) begin
                    n_dump_idx = '0;
                    n_state    = S_DUMP;
                end else if (out_free) begin
                    n_state          = S_IDLE;
                    n_res_valid      = 1'b1;
                    n_res.key_out    = '0;
                    n_res.value_out  = '0;
                    n_res.last       = 1'b1;
                    case (r_cmd.op)
                        OP_ADD: begin
                            if (r_count == CW'(TABLE_DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                do_add       = 1'b1;
                                n_count      = CW'(r_count + 1'b1);
                                n_res.status = ST_ADDED;
                            end
                        end
                        OP_SEARCH: begin
                            if (hit) begin
                                n_res.status    = ST_FOUND;
                                n_res.key_out   = r_cmd.key;
                                n_res.value_out = found_val;
                            end else begin
                                n_res.status = ST_NOT_FOUND;
                            end
                        end
                        OP_DELETE: begin
                            if (hit) begin
                                do_del       = 1'b1;
                                n_count      = CW'(r_count - 1'b1);
                                n_res.status = ST_DELETED;
                            end else begin
                                n_res.status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_res.status = ST_EMPTY;
                        end
                    endcase
                    n_res.entry_count_out = CNT_OUT_W'(n_count);
                end
            end
            S_DUMP: begin
                // emit cell 0 and rotate the held entries down by one place
                if (out_free) begin
                    do_rot                = 1'b1;
                    n_res_valid           = 1'b1;
                    n_res.status          = ST_DUMP;
                    n_res.key_out         = r_key[0];
                    n_res.value_out       = r_val[0];
                    n_res.entry_count_out = CNT_OUT_W'(r_count);
                    n_res.last            = (r_dump_idx == CW'(r_count - 1'b1));
                    if (n_res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_dump_idx = CW'(r_dump_idx + 1'b1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // cell next values: append, close the gap after a delete, or rotate
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            n_key[i] = r_key[i];
            n_val[i] = r_val[i];
            if (do_add && r_count == CW'(i)) begin
                n_key[i] = r_cmd.key;
                n_val[i] = r_cmd.value;
            end else if (do_rot && r_count == CW'(i + 1)) begin
                n_key[i] = r_key[0];
                n_val[i] = r_val[0];
            end else if ((do_del && after[i]) || do_rot) begin
                n_key[i] = r_key[(i + 1) % TABLE_DEPTH];
                n_val[i] = r_val[(i + 1) % TABLE_DEPTH];
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd   <= i_cmd;
            r_match <= match_vec;
        end
        r_dump_idx <= n_dump_idx;
        r_res      <= n_res;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            r_key[i] <= n_key[i];
            r_val[i] <= n_val[i];
        end
    end

endmodule

// ===== rtl/keyed_record_table_core.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_core
// Ordered key/value table with add, search, delete and dump operations.
//
//   Channel | Dir | Handshake             | Payload
//   s       | in  | i_s_tvalid/o_s_tready | i_s_tdata: op, key, value
//   m       | out | o_m_tvalid/i_m_tready | o_m_tdata: status, key_out,
//           |     |                       |   value_out, entry_count_out;
//           |     |                       |   o_m_tlast: last
//
// Add, search and delete run in the back end as a compare, then an act;
// dump then reads every held entry out of cell 0 in turn as the table
// rotates. A two-entry command queue lets input keep flowing while the
// back end works. Reset empties the table; no clearing pass is needed.
// Output stalls hold the back end; the queue then fills and stalls input.
// ----------------------------------------------------------------------------
module keyed_record_table_core import krt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // op[1:0], key[33:2], value[49:34]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // status[2:0], key_out[34:3],
                                               // value_out[50:35],
                                               // entry_count_out[57:51]
    output logic                  o_m_tlast
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    t_res res;

    krt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    krt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (o_m_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_tready)
    );

    // result packing, lowest field first
    assign o_m_tdata = {
        {(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
        res.entry_count_out,
        res.value_out,
        res.key_out,
        res.status
    };
    assign o_m_tlast = res.last;

endmodule
